FILE: rtl/core/multiplexed_seven_segment_controller_defines.svh
// assertion macros used by the display controller top level
`ifndef MULTIPLEXED_SEVEN_SEGMENT_CONTROLLER_DEFINES_SVH
`define MULTIPLEXED_SEVEN_SEGMENT_CONTROLLER_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet in reset
`define MSSC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet in reset
`define MSSC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/mssc_pkg.sv
// types, constants and font table of the seven-segment display controller
package mssc_pkg;

	localparam int DIGIT_COUNT = 3;
	localparam int CNT_W = $clog2(DIGIT_COUNT + 1);
	localparam logic [7:0] ERROR_MASK = 8'h80;

	typedef enum logic [2:0] {
		KIND_SET       = 3'd0,
		KIND_UNSET     = 3'd1,
		KIND_PUSH_MASK = 3'd2,
		KIND_PUSH_CHAR = 3'd3,
		KIND_CLEAR     = 3'd4,
		KIND_TICK      = 3'd5
	} kind_t;

	typedef enum logic {
		REG_DIGIT_LEVEL   = 1'b0,
		REG_SEGMENT_LEVEL = 1'b1
	} reg_idx_t;

	// one command beat as seen by the display state
	typedef struct packed {
		logic [2:0] kind;
		logic [3:0] digit_index;
		logic [7:0] mask_value;
		logic [7:0] char_code;
	} cmd_t;

	// state after the command, before polarity
	typedef struct packed {
		logic             accepted;
		logic [CNT_W-1:0] latch_pos;
		logic [6:0]       segments;
		logic [CNT_W-1:0] scan;
	} view_t;

	// bit 6 is segment a, bit 0 is segment g
	function automatic logic [7:0] font_lookup(input logic [7:0] c);
		logic [7:0] m;
		case (c)
			"0", "O":                m = 8'h7E;
			"1", "I":                m = 8'h30;
			"2":                     m = 8'h6D;
			"3":                     m = 8'h79;
			"4":                     m = 8'h33;
			"5", "S", "s":           m = 8'h5B;
			"6":                     m = 8'h5F;
			"7":                     m = 8'h70;
			"8":                     m = 8'h7F;
			"9", "g":                m = 8'h7B;
			"a", "A":                m = 8'h77;
			"b", "B":                m = 8'h1F;
			"c", "C", "(", "[", "{": m = 8'h4E;
			"d", "D":                m = 8'h3D;
			"e", "E":                m = 8'h4F;
			"f", "F":                m = 8'h47;
			"G":                     m = 8'h5E;
			"h":                     m = 8'h17;
			"H", "x", "X":           m = 8'h37;
			"i":                     m = 8'h50;
			"j":                     m = 8'h58;
			"l":                     m = 8'h06;
			"L":                     m = 8'h0E;
			"m", "M":                m = 8'h36;
			"n":                     m = 8'h15;
			"N":                     m = 8'h76;
			"o":                     m = 8'h1D;
			"p", "P":                m = 8'h67;
			"q", "Q":                m = 8'h73;
			"r", "R":                m = 8'h05;
			"t", "T":                m = 8'h07;
			"u", "v":                m = 8'h1C;
			"U":                     m = 8'h3E;
			"V":                     m = 8'h2A;
			"y":                     m = 8'h3B;
			"Y":                     m = 8'h2B;
			"z", "Z":                m = 8'h6C;
			")", "]", "}":           m = 8'h78;
			"\\":                    m = 8'h12;
			"/":                     m = 8'h24;
			"-":                     m = 8'h01;
			"_":                     m = 8'h08;
			" ":                     m = 8'h00;
			default:                 m = ERROR_MASK;
		endcase
		return m;
	endfunction

endpackage

FILE: rtl/core/mssc_display.sv
// digit mask store, scan counter and output latches
module mssc_display (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  mssc_pkg::cmd_t  cmd,
	output mssc_pkg::view_t view
);
	import mssc_pkg::*;

	logic [7:0]       masks_q [DIGIT_COUNT];
	logic [7:0]       masks_d [DIGIT_COUNT];
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] pos_q, pos_d;
	logic [6:0]       seg_q, seg_d;
	logic             acc;
	logic             idx_ok;
	logic [7:0]       push_val;

	assign idx_ok   = (cmd.digit_index != 4'd0) && (cmd.digit_index <= 4'(DIGIT_COUNT));
	assign push_val = (cmd.kind == KIND_PUSH_MASK) ? cmd.mask_value
		: font_lookup(cmd.char_code);

	always_comb begin
		masks_d = masks_q;
		cnt_d   = cnt_q;
		pos_d   = pos_q;
		seg_d   = seg_q;
		acc     = 1'b1;
		case (cmd.kind)
			KIND_SET, KIND_UNSET: begin
				if (idx_ok) begin
					for (int i = 0; i < DIGIT_COUNT; i++) begin
						if (cmd.digit_index == 4'(i + 1))
							masks_d[i] = (cmd.kind == KIND_SET) ? cmd.mask_value : 8'h00;
					end
				end else begin
					acc = 1'b0;
				end
			end
			KIND_PUSH_MASK, KIND_PUSH_CHAR: begin
				// everything moves one place left, new digit enters on the right
				for (int i = 0; i < DIGIT_COUNT - 1; i++)
					masks_d[i] = masks_q[i + 1];
				masks_d[DIGIT_COUNT-1] = push_val;
			end
			KIND_CLEAR: begin
				for (int i = 0; i < DIGIT_COUNT; i++)
					masks_d[i] = 8'h00;
				cnt_d = '0;
			end
			KIND_TICK: begin
				cnt_d = (cnt_q == CNT_W'(DIGIT_COUNT)) ? CNT_W'(1) : cnt_q + 1'b1;
				pos_d = cnt_d;
				seg_d = 7'h00;
				for (int i = 0; i < DIGIT_COUNT; i++) begin
					if (cnt_d == CNT_W'(i + 1))
						seg_d = seg_d | masks_q[i][6:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGIT_COUNT; i++)
				masks_q[i] <= 8'h00;
			cnt_q <= '0;
			pos_q <= '0;
			seg_q <= 7'h00;
		end else if (fire) begin
			masks_q <= masks_d;
			cnt_q   <= cnt_d;
			pos_q   <= pos_d;
			seg_q   <= seg_d;
		end
	end

	assign view.accepted  = acc;
	assign view.latch_pos = pos_d;
	assign view.segments  = seg_d;
	assign view.scan      = cnt_d;

endmodule

FILE: rtl/core/multiplexed_seven_segment_controller.sv
// top level of the multiplexed seven-segment display controller
//
//  channel   signals                                         direction
//  command   in_valid/in_ready, kind, digit_index,          in
//            mask_value, char_code
//  result    out_valid/out_ready, accepted, digit_enables,  out
//            segment_lines, scan_position
//  config    psel/penable/pwrite/paddr/pwdata/prdata/pready  apb slave
//
// the state update and font decode sit between the state flops and the result
// register, so one beat per cycle is sustained while the result is not stalled
// by a low out_ready
// reset clears digit masks, scan counter and latches, both levels come up high
// the result register frees as it is taken, so a stalled result only blocks
// input while out_ready is low
`include "multiplexed_seven_segment_controller_defines.svh"

module multiplexed_seven_segment_controller (
	input  logic        clk,
	input  logic        arst_n,
	// command channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  kind,
	input  logic [3:0]  digit_index,
	input  logic [7:0]  mask_value,
	input  logic [7:0]  char_code,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        accepted,
	output logic [2:0]  digit_enables,
	output logic [6:0]  segment_lines,
	output logic [1:0]  scan_position,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import mssc_pkg::*;

	logic             fire;
	logic             cfg_wr;
	logic             dig_lvl_q;
	logic             seg_lvl_q;
	cmd_t             cmd;
	view_t            view;
	logic [2:0]       en_on;
	logic [CNT_W+1:0] pos_wide;
	logic [CNT_W+1:0] scan_wide;

	logic             out_valid_q;
	logic             accepted_q;
	logic [2:0]       enables_q;
	logic [6:0]       segments_q;
	logic [1:0]       scan_q;

	// a beat goes in whenever the result register is empty or being emptied
	assign in_ready = !out_valid_q || out_ready;
	assign fire     = in_valid && in_ready;

	assign cmd.kind        = kind;
	assign cmd.digit_index = digit_index;
	assign cmd.mask_value  = mask_value;
	assign cmd.char_code   = char_code;

	mssc_display u_display (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.cmd    (cmd),
		.view   (view)
	);

	// register port: word address picks the register, no wait states
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_lvl_q <= 1'b1;
			seg_lvl_q <= 1'b1;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[2]))
				REG_DIGIT_LEVEL:   dig_lvl_q <= pwdata[0];
				REG_SEGMENT_LEVEL: seg_lvl_q <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[2]))
			REG_DIGIT_LEVEL:   prdata = {31'd0, dig_lvl_q};
			REG_SEGMENT_LEVEL: prdata = {31'd0, seg_lvl_q};
			default:           prdata = 32'd0;
		endcase
	end

	// one-hot enable from the latched digit position, zero meaning all off;
	// compared wide so that narrow counters never alias a digit number
	assign pos_wide  = {2'b00, view.latch_pos};
	assign scan_wide = {2'b00, view.scan};

	always_comb begin
		for (int k = 0; k < 3; k++)
			en_on[k] = (pos_wide == (CNT_W + 2)'(k + 1));
	end

	// result register, polarity applied as the beat is captured
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			accepted_q <= view.accepted;
			enables_q  <= dig_lvl_q ? en_on : ~en_on;
			segments_q <= seg_lvl_q ? view.segments : ~view.segments;
			scan_q     <= scan_wide[1:0];
		end
	end

	assign out_valid     = out_valid_q;
	assign accepted      = accepted_q;
	assign digit_enables = enables_q;
	assign segment_lines = segments_q;
	assign scan_position = scan_q;

	// only set and unset may be refused
	`MSSC_ASSERT_NXT(a_accept_only_index, fire && kind != KIND_SET && kind != KIND_UNSET, accepted, "mssc: non-index command refused")
	// a clear always leaves the scan at no digit
	`MSSC_ASSERT_NXT(a_clear_scan, fire && kind == KIND_CLEAR, scan_position == 2'd0, "mssc: clear did not reset scan")
	// with active-high digits at most one digit is ever enabled
	`MSSC_ASSERT_NOW(a_enables_onehot, out_valid && enables_q == (dig_lvl_q ? enables_q : ~enables_q), $onehot0(digit_enables), "mssc: more than one digit enabled")
	// a taken command always lands in the result register
	`MSSC_ASSERT_NXT(a_fire_result, fire, out_valid, "mssc: accepted beat lost")

endmodule
